/* hdl/text_console_writer_unit_defines.svh */
// text_console_writer_unit_defines.svh: assertion macros for the console writer
// the macros expect clk and arst_n to be in scope where they are used
`ifndef TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH

// same-cycle implication, off while in reset
`define TCW_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while in reset
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/tcw_pkg.sv */
// tcw_pkg: shared types and constants of the text console writer
// no dependencies; used by tcw_front, tcw_back and the top level
package tcw_pkg;

	localparam int IDX_W  = 11;
	localparam int CELL_W = 16;
	localparam int QDEPTH = 2;

	localparam logic [7:0] RESET_ATTR   = 8'h07;
	localparam logic [7:0] CH_NEWLINE   = 8'd10;
	localparam logic [7:0] CH_RETURN    = 8'd13;
	localparam logic [7:0] CH_BACKSPACE = 8'd8;
	localparam logic [7:0] CH_TAB       = 8'd9;
	localparam logic [7:0] CH_SPACE     = 8'h20;

	typedef enum logic [1:0] {
		OP_PUT      = 2'd0,
		OP_PUT_ATTR = 2'd1,
		OP_CLEAR    = 2'd2,
		OP_READ     = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		CMD_PUT,
		CMD_NEWLINE,
		CMD_RETURN,
		CMD_BACKSPACE,
		CMD_TAB,
		CMD_CLEAR,
		CMD_READ
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t        kind;
		logic [7:0]       ch;
		logic [7:0]       attr;
		logic [IDX_W-1:0] idx;
	} cmd_t;

endpackage

/* hdl/tcw_ram.sv */
// tcw_ram: generic simple dual-port RAM, one write and one registered read port
// no dependencies
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hdl/tcw_front.sv */
// tcw_front: accepts input beats, classifies them into commands, queues them
// depends on tcw_pkg and text_console_writer_unit_defines.svh
`include "text_console_writer_unit_defines.svh"

module tcw_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      hold,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                op,
	input  logic [7:0]                char_code,
	input  logic [7:0]                attribute,
	input  logic [tcw_pkg::IDX_W-1:0] cell_index,
	input  logic [7:0]                dflt_attr,
	output logic                      cmd_valid,
	output tcw_pkg::cmd_t             cmd,
	input  logic                      cmd_pop
);
	import tcw_pkg::*;

	localparam int QAW  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNTW = $clog2(QDEPTH + 1);

	cmd_t            q_mem [QDEPTH];
	logic [QAW-1:0]  wp_q;
	logic [QAW-1:0]  rp_q;
	logic [CNTW-1:0] cnt_q;
	cmd_t            cls;
	logic            push;

	assign in_stall  = hold || (cnt_q == CNTW'(QDEPTH));
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = q_mem[rp_q];

	always_comb begin
		cls.ch   = char_code;
		cls.attr = dflt_attr;
		cls.idx  = cell_index;
		cls.kind = CMD_PUT;
		unique case (op_t'(op))
			OP_READ:  cls.kind = CMD_READ;
			OP_CLEAR: cls.kind = CMD_CLEAR;
			OP_PUT, OP_PUT_ATTR: begin
				if (op_t'(op) == OP_PUT_ATTR) begin
					cls.attr = attribute;
				end
				unique case (char_code)
					CH_NEWLINE:   cls.kind = CMD_NEWLINE;
					CH_RETURN:    cls.kind = CMD_RETURN;
					CH_BACKSPACE: cls.kind = CMD_BACKSPACE;
					CH_TAB:       cls.kind = CMD_TAB;
					default:      cls.kind = CMD_PUT;
				endcase
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wp_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == QAW'(QDEPTH - 1)) ? '0 : wp_q + QAW'(1);
			end
			if (cmd_pop) begin
				rp_q <= (rp_q == QAW'(QDEPTH - 1)) ? '0 : rp_q + QAW'(1);
			end
			if (push && !cmd_pop) begin
				cnt_q <= cnt_q + CNTW'(1);
			end else if (cmd_pop && !push) begin
				cnt_q <= cnt_q - CNTW'(1);
			end
		end
	end

	`TCW_ASSERT_NEXT(a_head_held, cmd_valid && !cmd_pop, cmd_valid && $stable(cmd), "queue head lost")
	`TCW_ASSERT(a_cnt_range, cmd_pop, cmd_valid, "pop from empty queue")
	`TCW_ASSERT(a_hold_stalls, hold, in_stall && !push, "beat taken during clearing pass")

endmodule

/* hdl/tcw_back.sv */
// tcw_back: executes queued commands on the screen store, owns cursor and result
// depends on tcw_pkg, tcw_ram and text_console_writer_unit_defines.svh
`include "text_console_writer_unit_defines.svh"

module tcw_back #(
	parameter int COLUMNS   = 80,
	parameter int ROWS      = 25,
	parameter int TAB_WIDTH = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [7:0]                 dflt_attr,
	input  logic                       cmd_valid,
	input  tcw_pkg::cmd_t              cmd,
	output logic                       cmd_pop,
	output logic                       init_busy,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [tcw_pkg::IDX_W-1:0]  cursor_position,
	output logic [tcw_pkg::CELL_W-1:0] cell_value,
	output logic                       scrolled
);
	import tcw_pkg::*;

	localparam int CELLS   = COLUMNS * ROWS;
	localparam int LAST_RS = CELLS - COLUMNS;
	localparam int AW      = $clog2(CELLS);
	localparam int CW      = $clog2(CELLS + 1);
	localparam int COLW    = $clog2(COLUMNS);
	localparam int CNW     = $clog2(COLUMNS + 1);
	localparam int PW      = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
	localparam int DW      = (CNW > PW + 1) ? CNW : PW + 1;
	localparam int LAST_PH = (COLUMNS - 1) % TAB_WIDTH;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BLANK,
		ST_READ,
		ST_COPY,
		ST_DRAIN,
		ST_DONE
	} state_t;

	state_t              state_q;
	logic [AW-1:0]       rs_q;
	logic [COLW-1:0]     col_q;
	logic [PW-1:0]       ph_q;
	logic [AW-1:0]       wa_q;
	logic [CW-1:0]       wn_q;
	logic [7:0]          blk_attr_q;
	logic                init_q;
	logic                scr_pend_q;
	logic                scr_q;
	logic                rd_ok_q;
	logic [CELL_W-1:0]   val_q;
	logic [AW-1:0]       src_q;
	logic                cp_v_s1;
	logic [AW-1:0]       cp_dst_s1;
	logic                out_valid_q;
	logic [IDX_W-1:0]    cursor_q;
	logic [CELL_W-1:0]   cell_q;
	logic                scrolled_q;

	logic [AW-1:0]       cur;
	logic                at_end;
	logic                last_row;
	logic                next_row;
	logic [DW-1:0]       tab_gap;
	logic [DW-1:0]       room;
	logic [DW-1:0]       take;
	logic [AW-1:0]       d_rs;
	logic [COLW-1:0]     d_col;
	logic [PW-1:0]       d_ph;
	logic [AW-1:0]       d_wa;
	logic [CW-1:0]       d_wn;
	logic                d_wrap;
	logic                rd_ok;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [CELL_W-1:0]   ram_wdata;
	logic                ram_re;
	logic [AW-1:0]       ram_raddr;
	logic [CELL_W-1:0]   ram_rdata;

	assign cur       = rs_q + AW'(col_q);
	assign at_end    = (col_q == COLW'(COLUMNS - 1));
	assign last_row  = (rs_q == AW'(LAST_RS));
	assign cmd_pop   = (state_q == ST_IDLE) && cmd_valid;
	assign init_busy = init_q;
	assign rd_ok     = (32'(cmd.idx) < 32'(CELLS));

	assign out_valid       = out_valid_q;
	assign cursor_position = cursor_q;
	assign cell_value      = cell_q;
	assign scrolled        = scrolled_q;

	// cursor move and blank span of the command at the queue head
	always_comb begin
		d_rs     = rs_q;
		d_col    = col_q;
		d_ph     = ph_q;
		d_wa     = cur + AW'(1);
		d_wn     = '0;
		d_wrap   = 1'b0;
		next_row = 1'b0;
		tab_gap  = DW'(TAB_WIDTH) - DW'(ph_q);
		room     = DW'(COLUMNS) - DW'(col_q);
		take     = (tab_gap < room) ? tab_gap : room;
		unique case (cmd.kind)
			CMD_PUT: begin
				if (at_end) begin
					next_row = 1'b1;
				end else begin
					d_col = col_q + COLW'(1);
					d_ph  = (ph_q == PW'(TAB_WIDTH - 1)) ? '0 : ph_q + PW'(1);
				end
			end
			CMD_NEWLINE: begin
				d_wn     = CW'(COLUMNS - 1) - CW'(col_q);
				next_row = 1'b1;
			end
			CMD_RETURN: begin
				d_col = '0;
				d_ph  = '0;
				if (col_q == '0) begin
					d_wa = cur;
					d_wn = CW'(1);
				end else begin
					d_wa = rs_q + AW'(1);
					d_wn = CW'(col_q);
				end
			end
			CMD_BACKSPACE: begin
				if (cur != '0) begin
					d_wa = cur - AW'(1);
					d_wn = CW'(1);
					if (col_q != '0) begin
						d_col = col_q - COLW'(1);
						d_ph  = (ph_q == '0) ? PW'(TAB_WIDTH - 1) : ph_q - PW'(1);
					end else begin
						d_rs  = rs_q - AW'(COLUMNS);
						d_col = COLW'(COLUMNS - 1);
						d_ph  = PW'(LAST_PH);
					end
				end
			end
			CMD_TAB: begin
				d_wn = CW'(take) - CW'(1);
				if (take == room) begin
					next_row = 1'b1;
				end else begin
					d_col = col_q + COLW'(take);
					d_ph  = '0;
				end
			end
			CMD_CLEAR: begin
				d_wa  = '0;
				d_wn  = CW'(CELLS);
				d_rs  = '0;
				d_col = '0;
				d_ph  = '0;
			end
			CMD_READ: begin
				d_wn = '0;
			end
			default: begin
				d_wn = '0;
			end
		endcase
		if (next_row) begin
			d_col = '0;
			d_ph  = '0;
			if (last_row) begin
				d_wrap = 1'b1;
			end else begin
				d_rs = rs_q + AW'(COLUMNS);
			end
		end
	end

	// store port selection
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wa_q;
		ram_wdata = {blk_attr_q, CH_SPACE};
		priority if (cmd_pop && cmd.kind == CMD_PUT) begin
			ram_we    = 1'b1;
			ram_waddr = cur;
			ram_wdata = {cmd.attr, cmd.ch};
		end else if (cp_v_s1) begin
			ram_we    = 1'b1;
			ram_waddr = cp_dst_s1;
			ram_wdata = ram_rdata;
		end else if (state_q == ST_BLANK) begin
			ram_we = 1'b1;
		end else begin
			ram_we = 1'b0;
		end
		ram_re    = (state_q == ST_COPY) || (cmd_pop && cmd.kind == CMD_READ);
		ram_raddr = (state_q == ST_COPY) ? src_q : AW'(cmd.idx);
	end

	tcw_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELLS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_BLANK;
			rs_q        <= '0;
			col_q       <= '0;
			ph_q        <= '0;
			wa_q        <= '0;
			wn_q        <= CW'(CELLS);
			blk_attr_q  <= RESET_ATTR;
			init_q      <= 1'b1;
			scr_pend_q  <= 1'b0;
			scr_q       <= 1'b0;
			rd_ok_q     <= 1'b0;
			val_q       <= '0;
			src_q       <= '0;
			cp_v_s1     <= 1'b0;
			cp_dst_s1   <= '0;
			out_valid_q <= 1'b0;
			cursor_q    <= '0;
			cell_q      <= '0;
			scrolled_q  <= 1'b0;
		end else begin
			cp_v_s1 <= (state_q == ST_COPY);
			if (out_valid_q && !out_stall && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						rs_q       <= d_rs;
						col_q      <= d_col;
						ph_q       <= d_ph;
						wa_q       <= d_wa;
						wn_q       <= d_wn;
						blk_attr_q <= dflt_attr;
						scr_q      <= d_wrap;
						scr_pend_q <= d_wrap;
						rd_ok_q    <= rd_ok;
						val_q      <= '0;
						src_q      <= AW'(COLUMNS);
						priority if (cmd.kind == CMD_READ) begin
							state_q <= ST_READ;
						end else if (d_wn != '0) begin
							state_q <= ST_BLANK;
						end else if (d_wrap) begin
							state_q <= ST_COPY;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_READ: begin
					val_q   <= rd_ok_q ? ram_rdata : '0;
					state_q <= ST_DONE;
				end
				ST_BLANK: begin
					wa_q <= wa_q + AW'(1);
					wn_q <= wn_q - CW'(1);
					if (wn_q == CW'(1)) begin
						priority if (scr_pend_q) begin
							scr_pend_q <= 1'b0;
							src_q      <= AW'(COLUMNS);
							state_q    <= ST_COPY;
						end else if (init_q) begin
							init_q  <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_COPY: begin
					// one row up: read ahead, write in the next cycle
					cp_dst_s1 <= src_q - AW'(COLUMNS);
					src_q     <= src_q + AW'(1);
					if (src_q == AW'(CELLS - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					wa_q       <= AW'(LAST_RS);
					wn_q       <= CW'(COLUMNS);
					scr_pend_q <= 1'b0;
					state_q    <= ST_BLANK;
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						cursor_q    <= IDX_W'(cur);
						cell_q      <= val_q;
						scrolled_q  <= scr_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`TCW_ASSERT(a_pop_idle, cmd_pop, state_q == ST_IDLE && !init_q, "command taken while busy")
	`TCW_ASSERT(a_cursor_range, 1'b1, rs_q <= AW'(LAST_RS) && 32'(col_q) < 32'(COLUMNS), "cursor out of screen")
	`TCW_ASSERT(a_result_from_done, $rose(out_valid_q), $past(state_q == ST_DONE), "result not from completion")

endmodule

/* hdl/text_console_writer_unit.sv */
// text_console_writer_unit: top level of the text console writer
// depends on tcw_pkg, tcw_front and tcw_back
//
//  channel  direction  handshake            payload
//  in       sink       in_valid / in_stall  op, char_code, attribute, cell_index
//  out      source     out_valid/out_stall  cursor_position, cell_value, scrolled
//  cfg      sink       cfg_valid/cfg_ready  cfg_data (default attribute)
//
// put character: cell written when the command is popped, then ST_DONE; read cell: ST_READ, then ST_DONE
// newline, return, tab: blank the rest of the span in ST_BLANK, one blank cell write per cycle
// a scroll adds a row copy through the store (ST_COPY, ST_DRAIN) and a last-row blank
// clear screen: every cell blanked in ST_BLANK; all bound by the single store write port
// after reset a clearing pass over all COLUMNS * ROWS cells holds in_stall high
// a two-beat command queue lets input and output stall independently
module text_console_writer_unit #(
	parameter int COLUMNS   = 80,
	parameter int ROWS      = 25,
	parameter int TAB_WIDTH = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 op,
	input  logic [7:0]                 char_code,
	input  logic [7:0]                 attribute,
	input  logic [tcw_pkg::IDX_W-1:0]  cell_index,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [7:0]                 cfg_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [tcw_pkg::IDX_W-1:0]  cursor_position,
	output logic [tcw_pkg::CELL_W-1:0] cell_value,
	output logic                       scrolled
);
	import tcw_pkg::*;

	logic [7:0] attr_q;
	logic       cmd_valid;
	cmd_t       cmd;
	logic       cmd_pop;
	logic       init_busy;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= RESET_ATTR;
		end else if (cfg_valid && cfg_ready) begin
			attr_q <= cfg_data;
		end
	end

	tcw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.hold       (init_busy),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.char_code  (char_code),
		.attribute  (attribute),
		.cell_index (cell_index),
		.dflt_attr  (attr_q),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop)
	);

	tcw_back #(
		.COLUMNS   (COLUMNS),
		.ROWS      (ROWS),
		.TAB_WIDTH (TAB_WIDTH)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.dflt_attr       (attr_q),
		.cmd_valid       (cmd_valid),
		.cmd             (cmd),
		.cmd_pop         (cmd_pop),
		.init_busy       (init_busy),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.cursor_position (cursor_position),
		.cell_value      (cell_value),
		.scrolled        (scrolled)
	);

endmodule

/* dv/text_console_writer_unit_test.sv */
// text_console_writer_unit_test: self-checking testbench for the text console writer
// directed and random beats are predicted against a local copy of the screen and cursor,
// every reply is compared field by field; depends on tcw_pkg and text_console_writer_unit
module text_console_writer_unit_test;
	import tcw_pkg::*;

	localparam int COLS        = 80;
	localparam int ROWS_N      = 25;
	localparam int TAB_W       = 8;
	localparam int CELLS       = COLS * ROWS_N;
	localparam int IDX_MAX     = (1 << IDX_W) - 1;
	localparam int CYCLE_LIMIT = 20_000_000;

	typedef struct {
		logic [IDX_W-1:0]  cursor_idx;
		logic [CELL_W-1:0] cell_data;
		logic              scroll;
	} console_reply_t;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                in_valid   = 1'b0;
	logic                in_stall;
	logic [1:0]          op         = '0;
	logic [7:0]          char_code  = '0;
	logic [7:0]          attribute  = '0;
	logic [IDX_W-1:0]    cell_index = '0;
	logic                cfg_valid  = 1'b0;
	logic                cfg_ready;
	logic [7:0]          cfg_data   = '0;
	logic                out_valid;
	logic                out_stall  = 1'b0;
	logic [IDX_W-1:0]    cursor_position;
	logic [CELL_W-1:0]   cell_value;
	logic                scrolled;

	logic [CELL_W-1:0]   screen [CELLS];
	int unsigned         cursor_now;
	logic [7:0]          blank_attr;
	console_reply_t      awaited_replies [$];
	int                  errors     = 0;
	int unsigned         cycles     = 0;
	bit                  idle_on    = 1'b0;
	int                  stall_left = 0;

	text_console_writer_unit #(
		.COLUMNS(COLS),
		.ROWS(ROWS_N),
		.TAB_WIDTH(TAB_W)
	) dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic void blank_span(int unsigned from, int unsigned upto);
		for (int unsigned i = from; i < upto; i++)
			if (i < CELLS)
				screen[i] = {blank_attr, CH_SPACE};
	endfunction

	function automatic console_reply_t next_console_reply(op_t kind, logic [7:0] ch,
			logic [7:0] attr, logic [IDX_W-1:0] idx);
		console_reply_t r;
		int unsigned    col;
		int unsigned    row_start;
		int unsigned    target;
		logic [7:0]     put_attr;
		r.cell_data = '0;
		r.scroll    = 1'b0;
		case (kind)
		OP_PUT, OP_PUT_ATTR: begin
			put_attr  = (kind == OP_PUT) ? blank_attr : attr;
			col       = cursor_now % COLS;
			row_start = cursor_now - col;
			case (ch)
			CH_NEWLINE: begin
				target = row_start + COLS;
				blank_span(cursor_now + 1, target);
				cursor_now = target;
			end
			CH_RETURN: begin
				if (col == 0)
					blank_span(cursor_now, cursor_now + 1);
				else
					blank_span(row_start + 1, cursor_now + 1);
				cursor_now = row_start;
			end
			CH_BACKSPACE: begin
				if (cursor_now > 0) begin
					cursor_now--;
					blank_span(cursor_now, cursor_now + 1);
				end
			end
			CH_TAB: begin
				target = (col / TAB_W + 1) * TAB_W;
				if (target > COLS)
					target = COLS;
				blank_span(cursor_now + 1, row_start + target);
				cursor_now = row_start + target;
			end
			default: begin
				if (cursor_now < CELLS)
					screen[cursor_now] = {put_attr, ch};
				cursor_now++;
			end
			endcase
			if (cursor_now >= CELLS) begin
				for (int i = 0; i + COLS < CELLS; i++)
					screen[i] = screen[i + COLS];
				blank_span(CELLS - COLS, CELLS);
				cursor_now -= COLS;
				r.scroll = 1'b1;
			end
		end
		OP_CLEAR: begin
			blank_span(0, CELLS);
			cursor_now = 0;
		end
		OP_READ: begin
			if (idx < CELLS)
				r.cell_data = screen[idx];
		end
		endcase
		r.cursor_idx = cursor_now[IDX_W-1:0];
		return r;
	endfunction

	function automatic void note_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	// reply side: random stall bursts
	always @(posedge clk) begin
		if (stall_left > 1) begin
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 3) == 0) begin
			out_stall  <= 1'b1;
			stall_left <= $urandom_range(1, 11);
		end else begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end
	end

	always @(posedge clk) begin
		console_reply_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_replies.size() == 0) begin
				$error("reply with nothing awaited, cursor_position %0d", cursor_position);
				errors++;
			end else begin
				want = awaited_replies.pop_front();
				note_field("cursor_position", 16'(want.cursor_idx), 16'(cursor_position));
				note_field("cell_value", want.cell_data, cell_value);
				note_field("scrolled", 16'(want.scroll), 16'(scrolled));
			end
		end
	end

	task automatic send_beat(op_t kind, logic [7:0] ch, logic [7:0] attr,
			logic [IDX_W-1:0] idx);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		op         <= kind;
		char_code  <= ch;
		attribute  <= attr;
		cell_index <= idx;
		do @(posedge clk); while (in_stall);
		awaited_replies.push_back(next_console_reply(kind, ch, attr, idx));
	endtask

	task automatic drain_replies();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited_replies.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_default_attribute(logic [7:0] value);
		drain_replies();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid  <= 1'b0;
		blank_attr = value;
	endtask

	task automatic test_after_reset();
		send_beat(OP_READ, 8'h00, 8'h00, '0);
		send_beat(OP_READ, 8'h00, 8'h00, IDX_W'(CELLS - 1));
		send_beat(OP_READ, 8'hFF, 8'hFF, IDX_W'(IDX_MAX));
		send_beat(OP_READ, 8'h00, 8'h00, IDX_W'(1024));
	endtask

	task automatic test_control_chars();
		send_beat(OP_PUT, CH_BACKSPACE, 8'h00, '0);
		send_beat(OP_PUT, CH_RETURN, 8'h00, '0);
		send_beat(OP_PUT_ATTR, 8'hFF, 8'hFF, '0);
		send_beat(OP_PUT, 8'h00, 8'h00, '0);
		send_beat(OP_PUT_ATTR, "x", 8'h00, '0);
		send_beat(OP_PUT_ATTR, CH_TAB, 8'h5A, '0);
		send_beat(OP_PUT, "y", 8'h00, '0);
		send_beat(OP_PUT_ATTR, CH_RETURN, 8'hA5, '0);
		send_beat(OP_PUT, "z", 8'h00, '0);
		send_beat(OP_PUT_ATTR, CH_BACKSPACE, 8'h3C, '0);
		send_beat(OP_PUT, CH_NEWLINE, 8'h00, '0);
		send_beat(OP_PUT_ATTR, CH_NEWLINE, 8'hC3, '0);
		send_beat(OP_READ, 8'h00, 8'h00, '0);
		send_beat(OP_READ, 8'h00, 8'h00, IDX_W'(COLS));
		send_beat(OP_CLEAR, 8'h00, 8'h00, '0);
		send_beat(OP_READ, 8'h00, 8'h00, '0);
	endtask

	task automatic test_default_attribute();
		set_default_attribute(8'h00);
		send_beat(OP_PUT, "Q", 8'hFF, '0);
		send_beat(OP_PUT, CH_NEWLINE, 8'h00, '0);
		send_beat(OP_READ, 8'h00, 8'h00, '0);
		send_beat(OP_READ, 8'h00, 8'h00, IDX_W'(5));
		set_default_attribute(8'hFF);
		send_beat(OP_PUT, CH_BACKSPACE, 8'h00, '0);
		send_beat(OP_READ, 8'h00, 8'h00, IDX_W'(COLS - 1));
		send_beat(OP_READ, 8'h00, 8'h00, IDX_W'(5));
	endtask

	task automatic test_random_traffic(int beats, logic [7:0] attr_setting, bit idling);
		op_t              kind;
		logic [7:0]       ch;
		logic [IDX_W-1:0] idx;
		int unsigned      pick;
		set_default_attribute(attr_setting);
		for (int n = 0; n < beats; n++) begin
			if (n % 64 == 0)
				idle_on = idling && ($urandom_range(0, 3) != 0);
			pick = $urandom_range(0, 399);
			if (pick == 0)
				kind = OP_CLEAR;
			else if (pick < 80)
				kind = OP_READ;
			else if (pick < 200)
				kind = OP_PUT_ATTR;
			else
				kind = OP_PUT;
			pick = $urandom_range(0, 99);
			if (pick < 12)
				ch = CH_NEWLINE;
			else if (pick < 16)
				ch = CH_RETURN;
			else if (pick < 21)
				ch = CH_BACKSPACE;
			else if (pick < 26)
				ch = CH_TAB;
			else
				ch = 8'($urandom);
			pick = $urandom_range(0, 9);
			if (pick == 0)
				idx = IDX_W'($urandom_range(CELLS, IDX_MAX));
			else if (pick < 5)
				idx = IDX_W'((cursor_now + CELLS - $urandom_range(1, 160)) % CELLS);
			else
				idx = IDX_W'($urandom_range(0, CELLS - 1));
			send_beat(kind, ch, 8'($urandom), idx);
		end
	endtask

	initial begin
		for (int i = 0; i < CELLS; i++)
			screen[i] = {RESET_ATTR, CH_SPACE};
		cursor_now = 0;
		blank_attr = RESET_ATTR;
		repeat (4) @(posedge clk);
		arst_n  <= 1'b1;
		idle_on = 1'b1;
		test_after_reset();
		test_control_chars();
		test_default_attribute();
		test_random_traffic(500, 8'h00, 1'b1);
		test_random_traffic(500, 8'hFF, 1'b1);
		test_random_traffic(500, 8'($urandom), 1'b1);
		test_random_traffic(420, 8'($urandom), 1'b0);
		drain_replies();
		repeat (CELLS + 2 * COLS) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
